[hdl/lcc_pkg.sv]
// Shared constants, command codes and types for the LRU chunk cache.
`timescale 1ns / 1ps
`default_nettype none
package lcc_pkg;
    localparam int ENTRIES    = 128;
    localparam int LINE_WORDS = 128;
    localparam int SLOT_W     = $clog2(ENTRIES);
    localparam int WORD_W     = $clog2(LINE_WORDS);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int KEY_W      = 31;
    localparam int BYTES_W    = 11;
    localparam int CAP_W      = 8;
    localparam int DATA_W     = 64;
    localparam logic [BYTES_W-1:0] LINE_BYTES = 11'd1024;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ALLOC  = 2'd1,
        CMD_WRITE  = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_DECIDE = 6'b000100,
        ST_AGE    = 6'b001000,
        ST_FINISH = 6'b010000,
        ST_LREAD  = 6'b100000
    } state_t;
endpackage
`default_nettype wire

[hdl/lru_chunk_cache.sv]
// Top level: fully associative LRU cache with entry memories and line memory.
// Lookup and allocate: a tag/rank scan of all ENTRIES slots, then an aging pass over
// all ENTRIES slots and a finish step before the result; a lookup miss ends after the
// scan. A write word needs no sequencing state; a read word waits in LREAD for the line memory port.
// The done strobe marks each result for one cycle; the receiver cannot stall.
// Reset clears the valid bits, the fill count and capacity (to 128); memories hold no reset.
`timescale 1ns / 1ps
`default_nettype none
module lru_chunk_cache
    import lcc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          command,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [BYTES_W-1:0]  fill_bytes,
    input  wire logic [6:0]          slot,
    input  wire logic [6:0]          word_index,
    input  wire logic [DATA_W-1:0]   data_word,
    input  wire logic                cfg_we,
    input  wire logic [CAP_W-1:0]    cfg_wdata,
    output logic                     done,
    output logic                     hit,
    output logic [6:0]               slot_out,
    output logic [BYTES_W-1:0]       bytes_valid_out,
    output logic                     evicted,
    output logic [KEY_W-1:0]         evicted_key,
    output logic [DATA_W-1:0]        word_out
);
    // memories
    logic [KEY_W-1:0]   tag_mem   [ENTRIES];
    logic [SLOT_W-1:0]  rank_mem  [ENTRIES];
    logic [BYTES_W-1:0] bytes_mem [ENTRIES];
    logic [DATA_W-1:0]  line_mem  [ENTRIES*LINE_WORDS];

    logic [ENTRIES-1:0] valid_reg;
    logic [CNT_W-1:0]   used_reg;
    logic [CAP_W-1:0]   cap_reg;
    state_t             state_reg;

    logic               is_alloc_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [BYTES_W-1:0] vb_reg;
    logic [SLOT_W:0]    idx_reg;      // scan address, one wider to hold ENTRIES
    logic               rd_vld_reg;   // a read issued last cycle
    logic [SLOT_W-1:0]  rd_slot_reg;  // slot of that read
    logic               found_reg;
    logic [SLOT_W-1:0]  found_slot_reg;
    logic [SLOT_W-1:0]  found_rank_reg;
    logic [BYTES_W-1:0] found_bytes_reg;
    logic               vic_any_reg;
    logic [SLOT_W-1:0]  vic_slot_reg;
    logic [SLOT_W-1:0]  vic_rank_reg;
    logic [KEY_W-1:0]   vic_key_reg;
    logic [SLOT_W-1:0]  tgt_reg;      // slot made most recent
    logic [SLOT_W-1:0]  old_rank_reg; // its previous rank (bound for aging)
    logic               line_ok_reg;

    logic [KEY_W-1:0]   tag_q;
    logic [SLOT_W-1:0]  rank_q;
    logic [BYTES_W-1:0] bytes_q;
    logic [DATA_W-1:0]  line_q;

    logic [SLOT_W-1:0]  rd_addr;
    logic               rank_we;
    logic [SLOT_W-1:0]  rank_waddr;
    logic [SLOT_W-1:0]  rank_wdata;
    logic [CNT_W-1:0]   cap_eff;
    logic               in_range;

    assign busy = (state_reg != ST_IDLE);
    assign rd_addr = idx_reg[SLOT_W-1:0];
    assign in_range = ({1'b0, slot} < 8'(ENTRIES)) && ({1'b0, word_index} < 8'(LINE_WORDS));

    // clamp capacity to 1..ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = CNT_W'(1);
        else if (32'(cap_reg) > ENTRIES)
            cap_eff = CNT_W'(ENTRIES);
        else
            cap_eff = CNT_W'(cap_reg);
    end

    // rank write-back during aging; final rank 0 write in finish
    always_comb
    begin
        rank_we    = 1'b0;
        rank_waddr = rd_slot_reg;
        rank_wdata = rank_q + 1'b1;
        if (state_reg == ST_AGE && rd_vld_reg && valid_reg[rd_slot_reg]
            && rd_slot_reg != tgt_reg && rank_q < old_rank_reg)
            rank_we = 1'b1;
        if (state_reg == ST_FINISH)
        begin
            rank_we    = 1'b1;
            rank_waddr = tgt_reg;
            rank_wdata = '0;
        end
    end

    // entry memories: registered reads, single write port each
    always_ff @(posedge clk)
    begin
        tag_q   <= tag_mem[rd_addr];
        rank_q  <= rank_mem[rd_addr];
        bytes_q <= bytes_mem[rd_addr];
        if (rank_we)
            rank_mem[rank_waddr] <= rank_wdata;
        if (state_reg == ST_FINISH && is_alloc_reg)
        begin
            tag_mem[tgt_reg]   <= key_reg;
            bytes_mem[tgt_reg] <= vb_reg;
        end
    end

    // line memory
    always_ff @(posedge clk)
    begin
        if (start && !busy && command == CMD_WRITE && in_range)
            line_mem[{slot[SLOT_W-1:0], word_index[WORD_W-1:0]}] <= data_word;
        line_q <= line_mem[{slot[SLOT_W-1:0], word_index[WORD_W-1:0]}];
    end

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            valid_reg  <= '0;
            used_reg   <= '0;
            cap_reg    <= 8'd128;
            done       <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (cfg_we)
                cap_reg <= cfg_wdata;
            rd_vld_reg  <= 1'b0;
            rd_slot_reg <= rd_addr;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        hit <= 1'b0; slot_out <= '0; bytes_valid_out <= '0;
                        evicted <= 1'b0; evicted_key <= '0; word_out <= '0;
                        unique case (cmd_t'(command))
                            CMD_LOOKUP, CMD_ALLOC:
                            begin
                                is_alloc_reg <= (command == CMD_ALLOC);
                                key_reg      <= key;
                                vb_reg       <= (fill_bytes > LINE_BYTES) ? LINE_BYTES
                                                                          : fill_bytes;
                                idx_reg      <= '0;
                                found_reg    <= 1'b0;
                                vic_any_reg  <= 1'b0;
                                state_reg    <= ST_SCAN;
                            end
                            CMD_WRITE:
                                done <= 1'b1;
                            CMD_READ:
                            begin
                                line_ok_reg <= in_range;
                                state_reg   <= ST_LREAD;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    // issue next read, evaluate the previous one
                    if (idx_reg < (SLOT_W+1)'(ENTRIES))
                    begin
                        idx_reg    <= idx_reg + 1'b1;
                        rd_vld_reg <= 1'b1;
                    end
                    else
                        state_reg <= ST_DECIDE;
                    if (rd_vld_reg && valid_reg[rd_slot_reg])
                    begin
                        if (!found_reg && tag_q == key_reg)
                        begin
                            found_reg       <= 1'b1;
                            found_slot_reg  <= rd_slot_reg;
                            found_rank_reg  <= rank_q;
                            found_bytes_reg <= bytes_q;
                        end
                        if (!vic_any_reg || rank_q > vic_rank_reg)
                        begin
                            vic_any_reg  <= 1'b1;
                            vic_rank_reg <= rank_q;
                            vic_slot_reg <= rd_slot_reg;
                            vic_key_reg  <= tag_q;
                        end
                    end
                end
                ST_DECIDE:
                begin
                    idx_reg <= '0;
                    if (found_reg)
                    begin
                        tgt_reg <= found_slot_reg; old_rank_reg <= found_rank_reg;
                        hit <= 1'b1; slot_out <= 7'(found_slot_reg);
                        if (!is_alloc_reg)
                            bytes_valid_out <= found_bytes_reg;
                        state_reg <= ST_AGE;
                    end
                    else if (!is_alloc_reg)
                    begin
                        done      <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else if (used_reg < cap_eff)
                    begin
                        tgt_reg      <= used_reg[SLOT_W-1:0];
                        old_rank_reg <= used_reg[SLOT_W-1:0];
                        slot_out     <= 7'(used_reg[SLOT_W-1:0]);
                        state_reg    <= ST_AGE;
                    end
                    else
                    begin
                        tgt_reg <= vic_slot_reg; old_rank_reg <= vic_rank_reg;
                        slot_out <= 7'(vic_slot_reg);
                        evicted <= 1'b1; evicted_key <= vic_key_reg;
                        state_reg <= ST_AGE;
                    end
                end
                ST_AGE:
                begin
                    // read-modify-write, one entry a cycle, addresses never repeat
                    if (idx_reg < (SLOT_W+1)'(ENTRIES))
                    begin
                        idx_reg    <= idx_reg + 1'b1;
                        rd_vld_reg <= 1'b1;
                    end
                    else
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (is_alloc_reg && !found_reg && used_reg < cap_eff)
                    begin
                        valid_reg[tgt_reg] <= 1'b1;
                        used_reg           <= used_reg + 1'b1;
                    end
                    done      <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_LREAD:
                begin
                    // line word was read at the transfer edge
                    word_out  <= line_ok_reg ? line_q : '0;
                    done      <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // checks
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_reg) <= ENTRIES) else $error("fill count overflow");
    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        32'($countones(valid_reg)) == 32'(used_reg)) else $error("valid bits disagree");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");
    a_evict_nohit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit && evicted)) else $error("hit with eviction");
endmodule
`default_nettype wire
